FILE: hdl/ectab_pkg.sv
// Shared types, constants and codes for the Ewald coefficient table interpolation unit.
package ectab_pkg;

    // table geometry
    localparam int TABLE_SIZE = 1024;
    localparam int TAB_DEPTH  = TABLE_SIZE + 1;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);

    // field widths
    localparam int IDX_W   = 11;
    localparam int WORD_W  = 32;
    localparam int DIST_W  = 32;
    localparam int OUT_W   = 48;
    localparam int FRAC_W  = 31;
    localparam int LANES   = 3;
    localparam int LANE_DB = 2;                  // lane of the double-layer column

    // arithmetic widths
    localparam int PROD_W = 2 * WORD_W + 1;      // interpolation products and sum
    localparam int MAG_W  = 63;                  // |v| <= 2^62
    localparam int DIV_W  = 66;                  // 4*r^2 < 2^66
    localparam int QUO_W  = OUT_W;               // quotient bits resolved by the divider
    localparam int PRE_W  = MAG_W - QUO_W;       // numerator bits above the quotient range

    localparam logic [WORD_W-1:0] W0_ONE    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] INV_RESET = 32'd65536;

    // free-space numerators: 2^40 and 6*2^56 (the latter negative)
    localparam logic [MAG_W-1:0] FS_SINGLE_MAG = MAG_W'(64'd1 << 40);
    localparam logic [MAG_W-1:0] FS_DOUBLE_MAG = MAG_W'(64'd6 << 56);

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_INV_SPACING = 1'b0,
        CFG_FREE_SPACE  = 1'b1
    } t_cfg_reg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CUTOFF = 2'd1,
        ST_SAT    = 2'd2,
        ST_WRITE  = 2'd3
    } t_status;

    // what a word in flight turns into
    typedef enum logic [1:0] {
        KIND_EVAL   = 2'd0,
        KIND_CUTOFF = 2'd1,
        KIND_WRITE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  zero;       // distance is zero
    } t_ctl;

    // one column entering the divider
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [DIV_W-1:0] dvs;
        logic             neg;
        logic             nz;    // numerator is not zero
    } t_num;

    // one column inside the divider
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] nq;    // numerator bits shift out, quotient bits shift in
        logic             neg;
        logic             nz;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        logic [LANES-1:0][OUT_W-1:0] coeff;
        t_status                     status;
    } t_res;

endpackage

FILE: hdl/ectab_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module ectab_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1025,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: hdl/ectab_front.sv
// Front pipeline: input capture, scaling, table access, interpolation and divider setup.
module ectab_front
    import ectab_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_req_type,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic [LANES*WORD_W-1:0] i_entry,
    input  logic [DIST_W-1:0]       i_distance,
    input  logic [WORD_W-1:0]       i_inv_spacing,
    input  logic                    i_free_space,
    output t_ctl                    o_ctl,
    output t_num [LANES-1:0]        o_num
);

    // stage 1: captured word
    logic                    r1_valid;
    logic                    r1_eval;
    logic [IDX_W-1:0]        r1_idx;
    logic [LANES*WORD_W-1:0] r1_ent;
    logic [DIST_W-1:0]       r1_dist;

    // stage 2: scaled distance and r^2
    logic                    r2_valid;
    logic                    r2_eval;
    logic [IDX_W-1:0]        r2_idx;
    logic [LANES*WORD_W-1:0] r2_ent;
    logic [DIST_W-1:0]       r2_dist;
    logic [2*DIST_W-1:0]     r2_s;
    logic [2*DIST_W-1:0]     r2_rsq;

    // stage 3: table words
    t_ctl                    r3_ctl;
    logic [FRAC_W-1:0]       r3_f;
    logic [DIST_W-1:0]       r3_dist;
    logic [2*DIST_W-1:0]     r3_rsq;
    logic [LANES*WORD_W-1:0] rd_a;
    logic [LANES*WORD_W-1:0] rd_b;

    // stage 4: interpolation products
    t_ctl                    r4_ctl;
    logic [DIST_W-1:0]       r4_dist;
    logic [2*DIST_W-1:0]     r4_rsq;
    logic signed [PROD_W-1:0] r4_p0 [LANES];
    logic signed [PROD_W-1:0] r4_p1 [LANES];

    // stage 5: divider operands
    t_ctl                    r5_ctl;
    t_num [LANES-1:0]        r5_num;

    logic [DIST_W-1:0]       seg;
    logic                    beyond;
    logic [TAB_AW-1:0]       addr_a;
    logic [TAB_AW-1:0]       addr_b;
    logic                    wr_ok;
    logic                    we;
    t_kind                   s2_kind;
    logic signed [WORD_W:0]  w0s;
    logic signed [WORD_W:0]  fs;
    logic signed [PROD_W-1:0] s5_v [LANES];
    t_num [LANES-1:0]        s5_num;

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_eval <= i_req_type;
            r1_idx  <= i_entry_index;
            r1_ent  <= i_entry;
            r1_dist <= i_distance;
        end
    end

    // stage 2: s = r * inv_spacing (Q32.32) and r^2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_eval <= r1_eval;
            r2_idx  <= r1_idx;
            r2_ent  <= r1_ent;
            r2_dist <= r1_dist;
            r2_s    <= (2*DIST_W)'(r1_dist) * (2*DIST_W)'(i_inv_spacing);
            r2_rsq  <= (2*DIST_W)'(r1_dist) * (2*DIST_W)'(r1_dist);
        end
    end

    // index split, cutoff test and table port control
    always_comb begin
        seg    = r2_s[2*DIST_W-1:DIST_W];
        beyond = seg >= DIST_W'(TABLE_SIZE);
        addr_a = beyond ? TAB_AW'(TABLE_SIZE - 1) : seg[TAB_AW-1:0];
        addr_b = addr_a + TAB_AW'(1);
        wr_ok  = 32'(r2_idx) <= 32'(TABLE_SIZE);
        we     = i_en && r2_valid && !r2_eval && wr_ok;
        if (!r2_eval) begin
            s2_kind = KIND_WRITE;
        end else if (!i_free_space && beyond) begin
            s2_kind = KIND_CUTOFF;
        end else begin
            s2_kind = KIND_EVAL;
        end
    end

    ectab_ram #(
        .WIDTH (LANES*WORD_W),
        .DEPTH (TAB_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (TAB_AW'(r2_idx)),
        .i_wdata   (r2_ent),
        .i_re      (i_en),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // stage 3 alongside the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_en) begin
            r3_ctl.valid <= r2_valid;
            r3_ctl.kind  <= s2_kind;
            r3_ctl.zero  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_f    <= r2_s[DIST_W-1:DIST_W-FRAC_W];
            r3_dist <= r2_dist;
            r3_rsq  <= r2_rsq;
        end
    end

    // stage 4: (2^31 - f) * T[i] and f * T[i+1]
    assign w0s = $signed({1'b0, W0_ONE - {1'b0, r3_f}});
    assign fs  = $signed({2'b00, r3_f});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (i_en) begin
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_dist <= r3_dist;
            r4_rsq  <= r3_rsq;
            for (int k = 0; k < LANES; k++) begin
                r4_p0[k] <= w0s * $signed(rd_a[k*WORD_W +: WORD_W]);
                r4_p1[k] <= fs  * $signed(rd_b[k*WORD_W +: WORD_W]);
            end
        end
    end

    // stage 5: sum, sign/magnitude, numerator and divisor selection
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            s5_v[k] = r4_p0[k] + r4_p1[k];
            if (i_free_space) begin
                s5_num[k].mag = (k == LANE_DB) ? FS_DOUBLE_MAG : FS_SINGLE_MAG;
                s5_num[k].neg = (k == LANE_DB);
                s5_num[k].nz  = 1'b1;
                s5_num[k].dvs = (k == LANE_DB) ? DIV_W'(r4_rsq) : DIV_W'(r4_dist);
            end else begin
                s5_num[k].neg = s5_v[k][PROD_W-1];
                s5_num[k].mag = s5_v[k][PROD_W-1] ? MAG_W'(-s5_v[k]) : MAG_W'(s5_v[k]);
                s5_num[k].nz  = s5_v[k] != '0;
                s5_num[k].dvs = (k == LANE_DB) ? (DIV_W'(r4_rsq) << 2)
                                               : (DIV_W'(r4_dist) << 18);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else if (i_en) begin
            r5_ctl.valid <= r4_ctl.valid;
            r5_ctl.kind  <= r4_ctl.kind;
            r5_ctl.zero  <= r4_dist == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_num <= s5_num;
        end
    end

    assign o_ctl = r5_ctl;
    assign o_num = r5_num;

endmodule

FILE: hdl/ectab_div.sv
// Pipelined radix-2 divider for three columns with saturation and status.
module ectab_div
    import ectab_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  t_num [LANES-1:0] i_num,
    output logic             o_valid,
    output t_res             o_res
);

    t_ctl             r_ctl  [QUO_W+1];
    t_lane [LANES-1:0] r_lane [QUO_W+1];
    logic             r_fin_valid;
    t_res             r_fin;
    t_res             fin;
    logic             fin_sat;
    t_lane            ln;

    // one quotient bit: shift in the next numerator bit, subtract if it fits
    function automatic t_lane div_step(t_lane l);
        logic [DIV_W:0]   t;
        logic [DIV_W+1:0] dif;
        logic             ge;
        t_lane            res;
        t   = {l.rem, l.nq[QUO_W-1]};
        dif = {1'b0, t} - {2'b00, l.dvs};
        ge  = !dif[DIV_W+1];
        res     = l;
        res.rem = ge ? dif[DIV_W-1:0] : t[DIV_W-1:0];
        res.nq  = {l.nq[QUO_W-2:0], ge};
        return res;
    endfunction

    // entry stage: quotient overflow check and initial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_lane[0][k].rem <= DIV_W'(i_num[k].mag[MAG_W-1:QUO_W]);
                r_lane[0][k].ovf <= DIV_W'(i_num[k].mag[MAG_W-1:QUO_W]) >= i_num[k].dvs;
                r_lane[0][k].nq  <= i_num[k].mag[QUO_W-1:0];
                r_lane[0][k].dvs <= i_num[k].dvs;
                r_lane[0][k].neg <= i_num[k].neg;
                r_lane[0][k].nz  <= i_num[k].nz;
            end
        end
    end

    // one stage per quotient bit
    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g+1] <= '0;
            end else if (i_en) begin
                r_ctl[g+1] <= r_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < LANES; k++) begin
                    r_lane[g+1][k] <= div_step(r_lane[g][k]);
                end
            end
        end
    end

    // sign, saturation and status
    always_comb begin
        fin_sat = 1'b0;
        ln      = r_lane[QUO_W][0];
        for (int k = 0; k < LANES; k++) begin
            ln = r_lane[QUO_W][k];
            fin.coeff[k] = '0;
            if (r_ctl[QUO_W].zero) begin
                fin_sat = 1'b1;
                if (ln.nz) begin
                    fin.coeff[k] = ln.neg ? OUT_MIN : OUT_MAX;
                end
            end else if (ln.neg) begin
                if (ln.ovf || (ln.nq[QUO_W-1] && (ln.nq[QUO_W-2:0] != '0))) begin
                    fin.coeff[k] = OUT_MIN;
                    fin_sat      = 1'b1;
                end else begin
                    fin.coeff[k] = -ln.nq;
                end
            end else begin
                if (ln.ovf || ln.nq[QUO_W-1]) begin
                    fin.coeff[k] = OUT_MAX;
                    fin_sat      = 1'b1;
                end else begin
                    fin.coeff[k] = ln.nq;
                end
            end
        end
        unique case (r_ctl[QUO_W].kind)
            KIND_WRITE: begin
                fin.status = ST_WRITE;
                fin.coeff  = '0;
            end
            KIND_CUTOFF: begin
                fin.status = ST_CUTOFF;
                fin.coeff  = '0;
            end
            KIND_EVAL: begin
                fin.status = fin_sat ? ST_SAT : ST_OK;
            end
            default: begin
                fin.status = ST_OK;
                fin.coeff  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (i_en) begin
            r_fin_valid <= r_ctl[QUO_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin <= fin;
        end
    end

    assign o_valid = r_fin_valid;
    assign o_res   = r_fin;

endmodule

FILE: hdl/ewald_coeff_table_interp_unit.sv
// Top level: configuration registers, pipeline and output register with skid word.
//
// Takes one word per clock while o_stall is low and returns one result word per input
// word, in order. A write word stores one row of the 1025-entry table and returns status
// 3; an evaluate word returns S1, S2 and D1 in signed Q24.24. The path is five stages of
// scaling, table read and interpolation, one divider entry stage, 48 divider stages that
// each resolve one quotient bit, one result stage and the output register. o_stall rises
// only when the output is stalled and its skid word is full. Writes to configuration are
// to be made with no words in flight.
module ewald_coeff_table_interp_unit
    import ectab_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [WORD_W-1:0] i_entry_single_a,
    input  logic signed [WORD_W-1:0] i_entry_single_b,
    input  logic signed [WORD_W-1:0] i_entry_double,
    input  logic [DIST_W-1:0]        i_distance,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [OUT_W-1:0]  o_single_coeff_a,
    output logic signed [OUT_W-1:0]  o_single_coeff_b,
    output logic signed [OUT_W-1:0]  o_double_coeff,
    output logic [1:0]               o_status,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [0:0]               i_cfg_index,
    input  logic [WORD_W-1:0]        i_cfg_data
);

    logic [WORD_W-1:0] r_inv_spacing;
    logic              r_free_space;
    logic              en;
    t_ctl              f_ctl;
    t_num [LANES-1:0]  f_num;
    logic              p_valid;
    t_res              p_res;
    logic              r_out_valid;
    t_res              r_out;
    logic              r_skid_valid;
    t_res              r_skid;
    logic              out_free;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_spacing <= INV_RESET;
            r_free_space  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_data;
                CFG_FREE_SPACE:  r_free_space  <= i_cfg_data[0];
            endcase
        end
    end

    // the pipeline advances while the skid word is empty
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    ectab_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry       ({i_entry_double, i_entry_single_b, i_entry_single_a}),
        .i_distance    (i_distance),
        .i_inv_spacing (r_inv_spacing),
        .i_free_space  (r_free_space),
        .o_ctl         (f_ctl),
        .o_num         (f_num)
    );

    ectab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (f_ctl),
        .i_num   (f_num),
        .o_valid (p_valid),
        .o_res   (p_res)
    );

    // output register plus one skid word
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (out_free) begin
            r_out_valid <= p_valid;
        end else if (p_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= p_res;
        end else begin
            r_skid <= p_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_single_coeff_a = $signed(r_out.coeff[0]);
    assign o_single_coeff_b = $signed(r_out.coeff[1]);
    assign o_double_coeff   = $signed(r_out.coeff[LANE_DB]);
    assign o_status         = r_out.status;

endmodule
